// File: design/bpf_pkg.sv
// Shared types, widths and helpers for the Bezier path flattener.
// No dependencies; every other design file imports this package.
package bpf_pkg;

  localparam int COORD_W  = 24;  // Q15.8 coordinate
  localparam int IDX_W    = 10;  // reported buffer index
  localparam int CAP_W    = 11;  // capacity register
  localparam int NPTS_W   = 7;   // clamped curve point count, up to 64
  localparam int Q16_W    = 17;  // curve parameter t, u in Q16 (0..65536)
  localparam int DIVD_W   = 23;  // (i+1) << 16 with i+1 up to 64
  localparam int DCNT_W   = 5;   // divider step counter
  localparam int UU_W     = 34;  // t*t, u*u, t*u
  localparam int WGT_W    = 49;  // Bernstein weight, at most 2^48
  localparam int MUL_A_W  = 35;
  localparam int MUL_B_W  = 25;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int ACC_W    = 73;  // exact weighted sum plus rounding term
  localparam int WSPLIT   = 24;  // weight is multiplied in a low and a high part

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  typedef logic [COORD_W-1:0] coord_t;

  typedef enum logic [2:0] {
    OP_MOVE   = 3'd0,
    OP_LINE   = 3'd1,
    OP_RLINE  = 3'd2,
    OP_CUBIC  = 3'd3,
    OP_RCUBIC = 3'd4,
    OP_QUAD   = 3'd5,
    OP_RQUAD  = 3'd6,
    OP_NONE   = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_BLEND,
    ST_EMIT
  } fl_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_WMUL,
    B_WWB,
    B_AMUL,
    B_AWB,
    B_RND
  } blend_state_t;

  typedef struct packed {
    logic                start;
    logic [DIVD_W-1:0]   dividend;
    logic [NPTS_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic                start;
    logic                cubic;
    logic [Q16_W-1:0]    t;
  } blend_req_t;

  // Signed add clipped to the 24-bit coordinate range.
  function automatic coord_t sat_add(input coord_t a, input coord_t b);
    logic signed [COORD_W:0] s;
    s = $signed({a[COORD_W-1], a}) + $signed({b[COORD_W-1], b});
    if (s[COORD_W] != s[COORD_W-1]) begin
      return s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end
    return s[COORD_W-1:0];
  endfunction

  // Signed coordinate to offset-binary form (value plus 2^23), and back.
  function automatic coord_t to_ofs(input coord_t p);
    return {~p[COORD_W-1], p[COORD_W-2:0]};
  endfunction

endpackage

// File: design/bpf_div.sv
// Restoring divider, one quotient bit per cycle, for the curve parameter t.
// Depends on bpf_pkg.
module bpf_div
  import bpf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  output logic             done,
  output logic [Q16_W-1:0] quotient
);

  logic                busy_r;
  logic                done_r;
  logic [DCNT_W-1:0]   cnt_r;
  logic [NPTS_W-1:0]   rem_r;
  logic [DIVD_W-1:0]   quo_r;
  logic [NPTS_W-1:0]   dvs_r;

  logic [NPTS_W:0]     trial;
  logic                ge;
  logic [NPTS_W:0]     diff;
  logic                last_step;

  assign trial     = {rem_r, quo_r[DIVD_W-1]};
  assign ge        = trial >= {1'b0, dvs_r};
  assign diff      = trial - {1'b0, dvs_r};
  assign last_step = cnt_r == DCNT_W'(DIVD_W - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last_step;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last_step) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // The dividend shifts out of the top of quo_r while quotient bits enter below.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[NPTS_W-1:0] : trial[NPTS_W-1:0];
      quo_r <= {quo_r[DIVD_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r[Q16_W-1:0];

endmodule

// File: design/bpf_blend.sv
// Bernstein weights and the exact weighted sum of the control points, on one
// shared 35x25 multiplier with an accumulator. Depends on bpf_pkg.
module bpf_blend
  import bpf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  blend_req_t            req,
  input  logic [3:0][COORD_W-1:0] qx,
  input  logic [3:0][COORD_W-1:0] qy,
  output logic                  done,
  output coord_t                res_x,
  output coord_t                res_y
);

  blend_state_t         state_r, state_nxt;
  logic [Q16_W-1:0]     t_r, u_r;
  logic                 cubic_r;
  logic [UU_W-1:0]      uu_r, tt_r;
  logic [WGT_W-1:0]     w_r [4];
  logic [PROD_W-1:0]    prod_r;
  logic [ACC_W-1:0]     acc_r;
  logic [2:0]           wstep_r;
  logic [1:0]           term_r;
  logic                 half_r;
  logic                 coord_r;
  logic                 done_r;
  coord_t               rx_r, ry_r;

  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [PROD_W-1:0]    mul_p;
  logic [2:0]           wlast;
  logic [1:0]           tlast;
  logic [WGT_W-1:0]     wsel;
  logic [WGT_W-1:0]     pw, pw_dbl, pw_tri;
  logic [ACC_W-1:0]     addend, rnd;
  coord_t               rnd_v;

  assign wlast  = cubic_r ? 3'd5 : 3'd2;
  assign tlast  = cubic_r ? 2'd3 : 2'd2;
  assign wsel   = w_r[term_r];
  assign mul_p  = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign pw     = prod_r[WGT_W-1:0];
  assign pw_dbl = {pw[WGT_W-2:0], 1'b0};
  assign pw_tri = pw + pw_dbl;
  assign addend = half_r ? (ACC_W'(prod_r) << WSPLIT) : ACC_W'(prod_r);
  assign rnd    = acc_r + (cubic_r ? (ACC_W'(1) << 47) : (ACC_W'(1) << 31));
  assign rnd_v  = cubic_r ? rnd[48 +: COORD_W] : rnd[32 +: COORD_W];

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == B_AMUL) begin
      mul_a = half_r ? MUL_A_W'(wsel[WGT_W-1:WSPLIT]) : MUL_A_W'(wsel[WSPLIT-1:0]);
      mul_b = MUL_B_W'(coord_r ? qy[term_r] : qx[term_r]);
    end else begin
      unique case (wstep_r)
        3'd0: begin mul_a = MUL_A_W'(u_r); mul_b = MUL_B_W'(u_r); end
        3'd1: begin mul_a = MUL_A_W'(t_r); mul_b = MUL_B_W'(t_r); end
        3'd2: begin
          mul_a = cubic_r ? MUL_A_W'(uu_r) : MUL_A_W'(t_r);
          mul_b = MUL_B_W'(u_r);
        end
        3'd3: begin mul_a = MUL_A_W'(uu_r); mul_b = MUL_B_W'(t_r); end
        3'd4: begin mul_a = MUL_A_W'(tt_r); mul_b = MUL_B_W'(u_r); end
        default: begin mul_a = MUL_A_W'(tt_r); mul_b = MUL_B_W'(t_r); end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (req.start) state_nxt = B_WMUL;
      B_WMUL: state_nxt = B_WWB;
      B_WWB:  state_nxt = (wstep_r == wlast) ? B_AMUL : B_WMUL;
      B_AMUL: state_nxt = B_AWB;
      B_AWB:  state_nxt = (half_r && term_r == tlast) ? B_RND : B_AMUL;
      B_RND:  state_nxt = coord_r ? B_IDLE : B_AMUL;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == B_RND) && coord_r;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        if (req.start) begin
          t_r     <= req.t;
          u_r     <= Q16_W'(17'h10000 - req.t);
          cubic_r <= req.cubic;
          wstep_r <= '0;
        end
      end
      B_WMUL, B_AMUL: prod_r <= mul_p;
      B_WWB: begin
        unique case (wstep_r)
          3'd0: begin
            uu_r <= prod_r[UU_W-1:0];
            if (!cubic_r) w_r[0] <= pw;
          end
          3'd1: begin
            tt_r <= prod_r[UU_W-1:0];
            if (!cubic_r) w_r[2] <= pw;
          end
          3'd2: begin
            if (cubic_r) w_r[0] <= pw;
            else w_r[1] <= pw_dbl;
          end
          3'd3: w_r[1] <= pw_tri;
          3'd4: w_r[2] <= pw_tri;
          default: w_r[3] <= pw;
        endcase
        if (wstep_r == wlast) begin
          term_r  <= '0;
          half_r  <= 1'b0;
          coord_r <= 1'b0;
          acc_r   <= '0;
        end else begin
          wstep_r <= wstep_r + 1'b1;
        end
      end
      B_AWB: begin
        acc_r  <= acc_r + addend;
        half_r <= ~half_r;
        if (half_r) term_r <= term_r + 1'b1;
      end
      B_RND: begin
        if (coord_r) ry_r <= to_ofs(rnd_v);
        else rx_r <= to_ofs(rnd_v);
        acc_r   <= '0;
        coord_r <= 1'b1;
        term_r  <= '0;
        half_r  <= 1'b0;
      end
      default: ;
    endcase
  end

  assign done  = done_r;
  assign res_x = rx_r;
  assign res_y = ry_r;

endmodule

// File: design/bezier_path_flattener_top.sv
// Top level of the Bezier path flattener: command decode, vertex bookkeeping,
// output register. Depends on bpf_pkg, bpf_div and bpf_blend.
//
//   Channel  Direction  Handshake           Payload
//   in_      input      in_valid/in_ready   opcode, three points, curve_points
//   out_     output     out_valid/out_ready vertex_x/y, vertex_index, status, last
//   cfg_     input      cfg_wr_en           vertex_capacity
//
// A move, a line or a rejected command is taken when the output register is free.
// A curve of n points is sampled point by point: the bit-serial divider computes
// t, then the weight and blend steps run on the shared multiplier, then the point is
// emitted once the output register is free. No request is taken while a curve is in
// progress. Reset is synchronous.
module bezier_path_flattener_top
  import bpf_pkg::*;
#(
  parameter int MAX_VERTICES     = 1024,
  parameter int MAX_CURVE_POINTS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2:0]                 in_opcode,
  input  logic signed [COORD_W-1:0]  in_pt1_x,
  input  logic signed [COORD_W-1:0]  in_pt1_y,
  input  logic signed [COORD_W-1:0]  in_pt2_x,
  input  logic signed [COORD_W-1:0]  in_pt2_y,
  input  logic signed [COORD_W-1:0]  in_pt3_x,
  input  logic signed [COORD_W-1:0]  in_pt3_y,
  input  logic [5:0]                 in_curve_points,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [COORD_W-1:0]  out_vertex_x,
  output logic signed [COORD_W-1:0]  out_vertex_y,
  output logic [IDX_W-1:0]           out_vertex_index,
  output logic                       out_status,
  output logic                       out_last,
  input  logic                       cfg_wr_en,
  input  logic [CAP_W-1:0]           cfg_wr_data
);

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int SUM_W = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;

  fl_state_t               state_r, state_nxt;
  logic [CAP_W-1:0]        cap_r;
  logic [CNT_W-1:0]        count_r;
  coord_t                  cur_x_r, cur_y_r;
  logic [3:0][COORD_W-1:0] qx_r, qy_r;
  logic [NPTS_W-1:0]       n_r, k_r;
  logic                    cubic_r;
  logic                    out_valid_r;
  coord_t                  out_x_r, out_y_r;
  logic [IDX_W-1:0]        out_idx_r;
  logic                    out_st_r, out_last_r;

  opcode_t                 op;
  logic                    rel;
  coord_t                  a1x, a1y, a2x, a2y, a3x, a3y;
  logic [SUM_W-1:0]        cap_ext, cap_eff, cnt_ext;
  logic [NPTS_W-1:0]       n_raw, n_eff;
  logic                    line_full, curve_full;
  logic                    out_free, accept;
  logic                    is_line, is_curve;
  logic                    line_go, curve_go, emit_go, last_sample;
  logic                    out_load;
  coord_t                  ox_nxt, oy_nxt;
  logic [IDX_W-1:0]        oidx_nxt;
  logic                    ost_nxt;

  div_req_t                div_req;
  logic                    div_done;
  logic [Q16_W-1:0]        div_q;
  blend_req_t              blend_req;
  logic                    blend_done;
  coord_t                  res_x, res_y;

  assign op       = opcode_t'(in_opcode);
  assign rel      = (op == OP_RLINE) || (op == OP_RCUBIC) || (op == OP_RQUAD);
  assign a1x      = rel ? sat_add(cur_x_r, in_pt1_x) : in_pt1_x;
  assign a1y      = rel ? sat_add(cur_y_r, in_pt1_y) : in_pt1_y;
  assign a2x      = rel ? sat_add(cur_x_r, in_pt2_x) : in_pt2_x;
  assign a2y      = rel ? sat_add(cur_y_r, in_pt2_y) : in_pt2_y;
  assign a3x      = rel ? sat_add(cur_x_r, in_pt3_x) : in_pt3_x;
  assign a3y      = rel ? sat_add(cur_y_r, in_pt3_y) : in_pt3_y;

  assign cap_ext  = SUM_W'(cap_r);
  assign cnt_ext  = SUM_W'(count_r);
  assign n_raw    = NPTS_W'(in_curve_points);

  always_comb begin
    if (cap_ext == '0) cap_eff = SUM_W'(1);
    else if (cap_ext > SUM_W'(MAX_VERTICES)) cap_eff = SUM_W'(MAX_VERTICES);
    else cap_eff = cap_ext;
    if (n_raw == '0) n_eff = NPTS_W'(1);
    else if (n_raw > NPTS_W'(MAX_CURVE_POINTS)) n_eff = NPTS_W'(MAX_CURVE_POINTS);
    else n_eff = n_raw;
  end

  assign line_full   = cnt_ext >= cap_eff;
  assign curve_full  = (cnt_ext + SUM_W'(n_eff)) > cap_eff;
  assign out_free    = !out_valid_r || out_ready;
  assign in_ready    = (state_r == ST_IDLE) && out_free;
  assign accept      = in_valid && in_ready;
  assign is_line     = (op == OP_LINE) || (op == OP_RLINE);
  assign is_curve    = (op == OP_CUBIC) || (op == OP_RCUBIC) ||
                       (op == OP_QUAD) || (op == OP_RQUAD);
  assign line_go     = accept && is_line && !line_full;
  assign curve_go    = accept && is_curve && !curve_full;
  assign last_sample = k_r == n_r;
  assign emit_go     = (state_r == ST_EMIT) && out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (curve_go) state_nxt = ST_DIV;
      ST_DIV:   if (div_done) state_nxt = ST_BLEND;
      ST_BLEND: if (blend_done) state_nxt = ST_EMIT;
      ST_EMIT:  if (emit_go) state_nxt = last_sample ? ST_IDLE : ST_DIV;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer and the next output payload.
  always_comb begin
    div_req.start     = curve_go || (emit_go && !last_sample);
    div_req.dividend  = curve_go ? {NPTS_W'(1), 16'b0} : {k_r + 1'b1, 16'b0};
    div_req.divisor   = curve_go ? n_eff : n_r;
    blend_req.start   = (state_r == ST_DIV) && div_done;
    blend_req.cubic   = cubic_r;
    blend_req.t       = div_q;

    out_load = 1'b0;
    ox_nxt   = '0;
    oy_nxt   = '0;
    oidx_nxt = '0;
    ost_nxt  = 1'b0;
    if (emit_go) begin
      out_load = 1'b1;
      ox_nxt   = res_x;
      oy_nxt   = res_y;
      oidx_nxt = IDX_W'(count_r);
    end else if (accept) begin
      if (op == OP_MOVE) begin
        out_load = 1'b1;
        ox_nxt   = in_pt1_x;
        oy_nxt   = in_pt1_y;
      end else if (is_line && !line_full) begin
        out_load = 1'b1;
        ox_nxt   = a1x;
        oy_nxt   = a1y;
        oidx_nxt = IDX_W'(count_r);
      end else if ((is_line && line_full) || (is_curve && curve_full)) begin
        out_load = 1'b1;
        ost_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CAP_RESET;
      count_r     <= CNT_W'(1);
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) cap_r <= cfg_wr_data;
      if (accept && op == OP_MOVE) begin
        count_r <= CNT_W'(1);
        cur_x_r <= in_pt1_x;
        cur_y_r <= in_pt1_y;
      end else if (line_go) begin
        count_r <= count_r + 1'b1;
        cur_x_r <= a1x;
        cur_y_r <= a1y;
      end else if (emit_go) begin
        count_r <= count_r + 1'b1;
        if (last_sample) begin
          cur_x_r <= res_x;
          cur_y_r <= res_y;
        end
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x_r    <= ox_nxt;
      out_y_r    <= oy_nxt;
      out_idx_r  <= oidx_nxt;
      out_st_r   <= ost_nxt;
      out_last_r <= !emit_go || last_sample;
    end
    if (curve_go) begin
      qx_r    <= {to_ofs(a3x), to_ofs(a2x), to_ofs(a1x), to_ofs(cur_x_r)};
      qy_r    <= {to_ofs(a3y), to_ofs(a2y), to_ofs(a1y), to_ofs(cur_y_r)};
      n_r     <= n_eff;
      k_r     <= NPTS_W'(1);
      cubic_r <= (op == OP_CUBIC) || (op == OP_RCUBIC);
    end else if (emit_go && !last_sample) begin
      k_r <= k_r + 1'b1;
    end
  end

  bpf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  bpf_blend u_blend (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (blend_req),
    .qx    (qx_r),
    .qy    (qy_r),
    .done  (blend_done),
    .res_x (res_x),
    .res_y (res_y)
  );

  assign out_valid        = out_valid_r;
  assign out_vertex_x     = out_x_r;
  assign out_vertex_y     = out_y_r;
  assign out_vertex_index = out_idx_r;
  assign out_status       = out_st_r;
  assign out_last         = out_last_r;

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != '0)
    else $error("vertex count reached zero");

  a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide phase");

  a_blend_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    blend_done |-> state_r == ST_BLEND)
    else $error("blend finished outside the blend phase");

  a_emit_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_go && !last_sample) |=> state_r == ST_DIV && k_r != '0)
    else $error("curve sampling did not continue after an emitted point");

endmodule
